// File: hw/rtl/tabx_pkg.sv
// Package for the tab expander: widths, character codes, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tabx_pkg;

   // field and counter widths
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 16;
   localparam int TABW_W     = 7;
   localparam int MAX_TAB    = 64;
   localparam int MAX_RES    = 64;
   localparam int REM_W      = $clog2(MAX_TAB);
   localparam int STEP_W     = $clog2(COUNT_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // spaces allowed for a tab that also ends the string (room for the done transfer)
   localparam logic [TABW_W-1:0] END_TAB_CAP = TABW_W'(MAX_RES - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT = 1'b1;

   // register reset values
   localparam logic [TABW_W-1:0]  TAB_WIDTH_RST = 7'd8;
   localparam logic [COUNT_W-1:0] OUT_LIMIT_RST = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_TAB_LOAD,
      ST_EMIT,
      ST_DONE
   } tabx_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic div_step;
      logic tab_load;
      logic emit;
      logic set_ovf;
      logic done_load;
   } tabx_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_is_nul;
      logic in_is_tab;
      logic in_ends;
      logic ovf;
      logic div_last;
      logic fits;
      logic last_char;
      logic ends;
      logic out_free;
   } tabx_sts_type;

endpackage

// File: hw/rtl/tabx_chan_if.sv
// Stream interfaces for the tab expander: request and response channels.
// Depends on tabx_pkg for the field widths.
interface tabx_req_if
   import tabx_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              end_of_string;

   modport source (output valid, output in_char, output end_of_string, input ready);
   modport sink   (input valid, input in_char, input end_of_string, output ready);
endinterface

interface tabx_rsp_if
   import tabx_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  out_char;
   logic               run_last;
   logic               is_done;
   logic [COUNT_W-1:0] total_len;
   logic               overflow;

   modport source (output valid, output out_char, output run_last, output is_done,
                   output total_len, output overflow, input ready);
   modport sink   (input valid, input out_char, input run_last, input is_done,
                   input total_len, input overflow, output ready);
endinterface

// File: hw/rtl/tab_expander_unit.sv
// Top level of the tab expander: controller plus datapath on two stream channels.
// Depends on tabx_pkg, tabx_chan_if, tabx_ctrl and tabx_datapath.
//
// Bytes of a string come in on req_ch and characters go out on rsp_ch, one per
// transfer, with a done transfer carrying the length and overflow flag at the end
// of each string (NUL or end_of_string). An ordinary byte is accepted and then
// emitted. A dropped byte (after overflow) is only accepted. A tab works out the
// tab-stop remainder one bit per cycle over the 16-bit column count, then loads
// the space count and emits each space. A string end adds the done transfer.
// The response register lets the next byte be accepted while the last character
// still waits on rsp_ch; while rsp_ch stalls, emission stalls with it.
// csr_index 0 writes tab_width, 1 writes out_limit; write only while idle.
module tab_expander_unit
   import tabx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tabx_req_if.sink              req_ch,
   tabx_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tabx_cmd_type cmd;
   tabx_sts_type sts;

   tabx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tabx_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_char   (req_ch.in_char),
      .in_eos    (req_ch.end_of_string),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_char  (rsp_ch.out_char),
      .rsp_last  (rsp_ch.run_last),
      .rsp_done  (rsp_ch.is_done),
      .rsp_len   (rsp_ch.total_len),
      .rsp_ovf   (rsp_ch.overflow)
   );

endmodule

// File: hw/rtl/tabx_ctrl.sv
// Controller of the tab expander: sequences accept, tab-stop remainder,
// space emission and the done transfer. Depends on tabx_pkg.
module tabx_ctrl
   import tabx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tabx_sts_type sts,
   output tabx_cmd_type cmd
);

   tabx_state_type state_ff, state_in;
   logic           accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.in_is_nul || sts.ovf) begin
                  state_in = sts.in_ends ? ST_DONE : ST_IDLE;
               end else if (sts.in_is_tab) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = ST_TAB_LOAD;
            end
         end
         ST_TAB_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.fits) begin
               state_in = sts.ends ? ST_DONE : ST_IDLE;
            end else if (sts.out_free && sts.last_char) begin
               state_in = sts.ends ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_TAB_LOAD: begin
            cmd.tab_load = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit    = sts.fits && sts.out_free;
            cmd.set_ovf = !sts.fits;
         end
         ST_DONE: begin
            cmd.done_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/tabx_datapath.sv
// Datapath of the tab expander: configuration registers, column counter,
// bit-serial tab-stop remainder, space counter and the response register.
// Depends on tabx_pkg.
module tabx_datapath
   import tabx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CHAR_W-1:0]     in_char,
   input  logic                  in_eos,
   input  tabx_cmd_type          cmd,
   output tabx_sts_type          sts,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_char,
   output logic                  rsp_last,
   output logic                  rsp_done,
   output logic [COUNT_W-1:0]    rsp_len,
   output logic                  rsp_ovf
);

   logic [TABW_W-1:0]  tab_width_ff;
   logic [COUNT_W-1:0] out_limit_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               ovf_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               ends_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff;
   logic [TABW_W-1:0]  left_ff;

   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;
   logic               rsp_done_ff;
   logic [COUNT_W-1:0] rsp_len_ff;
   logic               rsp_ovf_ff;

   logic [TABW_W-1:0]  tabw_eff;
   logic [TABW_W-1:0]  rem_trial;
   logic [TABW_W-1:0]  rem_sub;
   logic [TABW_W-1:0]  tab_cnt;
   logic [COUNT_W:0]   count_next;
   logic               next_fails;
   logic               in_is_nul;
   logic               in_is_tab;
   logic               out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_WIDTH_RST;
         out_limit_ff <= OUT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAB_WIDTH: tab_width_ff <= csr_wdata[TABW_W-1:0];
            CSR_OUT_LIMIT: out_limit_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the tab width into one to MAX_TAB
   always_comb begin
      if (tab_width_ff == '0) begin
         tabw_eff = TABW_W'(1);
      end else if (tab_width_ff > TABW_W'(MAX_TAB)) begin
         tabw_eff = TABW_W'(MAX_TAB);
      end else begin
         tabw_eff = tab_width_ff;
      end
   end

   // one restoring step of count modulo tab width, most significant bit first
   always_comb begin
      rem_trial = {rem_ff, count_ff[step_ff]};
      rem_sub   = rem_trial - tabw_eff;
      rem_in    = (rem_trial >= tabw_eff) ? rem_sub[REM_W-1:0] : rem_trial[REM_W-1:0];
   end

   assign tab_cnt    = tabw_eff - {1'b0, rem_ff};
   assign count_next = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign next_fails = count_next >= {1'b0, out_limit_ff};
   assign in_is_nul  = (in_char == CH_NUL);
   assign in_is_tab  = (in_char == CH_TAB);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // item capture, remainder and space counter
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= in_is_tab ? CH_SPACE : in_char;
         ends_ff <= in_eos || in_is_nul;
         rem_ff  <= '0;
         step_ff <= STEP_W'(COUNT_W - 1);
         left_ff <= TABW_W'(1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         step_ff <= step_ff - STEP_W'(1);
      end else if (cmd.tab_load) begin
         left_ff <= (ends_ff && tab_cnt > END_TAB_CAP) ? END_TAB_CAP : tab_cnt;
      end else if (cmd.emit) begin
         left_ff <= left_ff - TABW_W'(1);
      end
   end

   // column counter and sticky overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.done_load) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.emit) begin
            count_ff <= count_next[COUNT_W-1:0];
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // response register: load on emit or done, drop valid once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.done_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff <= char_ff;
         rsp_last_ff <= !ends_ff && ((left_ff == TABW_W'(1)) || next_fails);
         rsp_done_ff <= 1'b0;
         rsp_len_ff  <= '0;
         rsp_ovf_ff  <= 1'b0;
      end else if (cmd.done_load) begin
         rsp_char_ff <= CH_NUL;
         rsp_last_ff <= 1'b1;
         rsp_done_ff <= 1'b1;
         rsp_len_ff  <= count_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   // status
   always_comb begin
      sts.in_is_nul = in_is_nul;
      sts.in_is_tab = in_is_tab;
      sts.in_ends   = in_eos || in_is_nul;
      sts.ovf       = ovf_ff;
      sts.div_last  = (step_ff == '0);
      sts.fits      = count_ff < out_limit_ff;
      sts.last_char = (left_ff == TABW_W'(1));
      sts.ends      = ends_ff;
      sts.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_done  = rsp_done_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_ovf   = rsp_ovf_ff;

endmodule
